@@ rtl/core/dtfx_pkg.sv @@
`default_nettype none

package dtfx_pkg;

    // default sizes of the number format
    localparam int DEF_INT_BITS    = 32;
    localparam int DEF_FRAC_BITS   = 32;
    localparam int DEF_WEIGHT_BITS = 40;

    // digit weight table: entry k holds 2^WEIGHT_BITS / 10^(k+1), truncated;
    // the last entry is zero for every weight width up to 56 bits
    localparam int WEIGHT_ENTRIES = 18;
    localparam int WCNT_W         = $clog2(WEIGHT_ENTRIES);
    localparam logic [WCNT_W-1:0] WCNT_LAST = WCNT_W'(WEIGHT_ENTRIES - 1);

    // character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [3:0] {
        PH_LEAD = 4'b0001,
        PH_INT  = 4'b0010,
        PH_FRAC = 4'b0100,
        PH_STOP = 4'b1000
    } dtfx_phase_t;

    typedef struct packed {
        dtfx_phase_t phase;
        logic        negative;
        logic        saturated;
    } dtfx_flags_t;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_string;
    } dtfx_char_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic               overflow;
    } dtfx_result_t;

    // largest integer part: 2^(ibits-1)-1, capped so the magnitude fits 63 bits
    function automatic logic [63:0] whole_limit(input int ibits, input int fbits);
        logic [63:0] lim_a;
        logic [63:0] lim_b;
        lim_a = (64'd1 << (ibits - 1)) - 64'd1;
        lim_b = 64'h7FFF_FFFF_FFFF_FFFF >> fbits;
        return (lim_a < lim_b) ? lim_a : lim_b;
    endfunction

    // weight of the fraction digit at position k (k = 0 is the tenths digit)
    function automatic logic [63:0] weight_at(input int wbits, input int k);
        logic [63:0] w;
        w = 64'd1 << wbits;
        for (int i = 0; i <= k; i++)
        begin
            w = w / 64'd10;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/dtfx_step.sv @@
`default_nettype none

module dtfx_step
    import dtfx_pkg::*;
#(
    parameter int INT_BITS    = DEF_INT_BITS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
)
(
    input  wire logic [7:0]             character,
    input  wire dtfx_flags_t            flags,
    input  wire logic [INT_BITS-1:0]    whole,
    input  wire logic [WEIGHT_BITS-1:0] frac,
    input  wire logic [WCNT_W-1:0]      wcnt,
    output      dtfx_flags_t            flags_next,
    output      logic [INT_BITS-1:0]    whole_next,
    output      logic [WEIGHT_BITS-1:0] frac_next,
    output      logic [WCNT_W-1:0]      wcnt_next
);

    localparam logic [INT_BITS+3:0] LIM = (INT_BITS+4)'(whole_limit(INT_BITS, FRAC_BITS));

    logic [WEIGHT_BITS-1:0] weight_tab [WEIGHT_ENTRIES];

    for (genvar i = 0; i < WEIGHT_ENTRIES; i++)
    begin : g_weight
        assign weight_tab[i] = WEIGHT_BITS'(weight_at(WEIGHT_BITS, i));
    end

    logic                     is_digit;
    logic [3:0]               digit;
    logic                     take_int;
    logic                     take_frac;
    logic [INT_BITS+3:0]      whole_x10;
    logic [WEIGHT_BITS+3:0]   frac_add;

    assign is_digit  = (character >= CH_ZERO) && (character <= CH_NINE);
    assign digit     = 4'(character - CH_ZERO);
    // whole * 10 + digit as shift-add, wide enough not to wrap
    assign whole_x10 = ({4'd0, whole} << 3) + ({4'd0, whole} << 1) + (INT_BITS+4)'(digit);
    assign frac_add  = (WEIGHT_BITS+4)'(digit) * {4'd0, weight_tab[wcnt]};

    always_comb
    begin
        flags_next = flags;
        take_int   = 1'b0;
        take_frac  = 1'b0;
        case (flags.phase)
            PH_LEAD:
            begin
                if (character == CH_SPACE || character == CH_TAB || character == CH_CR)
                begin
                    flags_next.phase = PH_LEAD;
                end
                else if (character == CH_MINUS || character == CH_PLUS)
                begin
                    flags_next.negative = (character == CH_MINUS);
                    flags_next.phase    = PH_INT;
                end
                else if (is_digit)
                begin
                    take_int         = 1'b1;
                    flags_next.phase = PH_INT;
                end
                else if (character == CH_POINT)
                begin
                    flags_next.phase = PH_FRAC;
                end
                else
                begin
                    flags_next.phase = PH_STOP;
                end
            end
            PH_INT:
            begin
                if (is_digit)
                begin
                    take_int = 1'b1;
                end
                else if (character == CH_POINT)
                begin
                    flags_next.phase = PH_FRAC;
                end
                else
                begin
                    flags_next.phase = PH_STOP;
                end
            end
            PH_FRAC:
            begin
                if (is_digit)
                begin
                    take_frac = 1'b1;
                end
                else
                begin
                    flags_next.phase = PH_STOP;
                end
            end
            default:
            begin
                flags_next.phase = PH_STOP;
            end
        endcase

        whole_next = whole;
        if (take_int)
        begin
            if (flags.saturated || whole_x10 > LIM)
            begin
                whole_next           = INT_BITS'(LIM);
                flags_next.saturated = 1'b1;
            end
            else
            begin
                whole_next = INT_BITS'(whole_x10);
            end
        end

        // the fraction sum stays below one, so it never carries out
        frac_next = frac;
        wcnt_next = wcnt;
        if (take_frac)
        begin
            frac_next = frac + WEIGHT_BITS'(frac_add);
            if (wcnt != WCNT_LAST)
            begin
                wcnt_next = wcnt + WCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/decimal_text_to_fixed_point.sv @@
// decimal text to signed fixed point
//
// char channel: one ascii character per transaction (char_valid / char_stall,
// payload char_data). leading space, tab and cr are skipped, then an optional
// sign, integer digits, an optional point and fraction digits. the first
// character that fits none of these ends parsing; later ones are ignored.
// a transaction with end_of_string set closes the string.
// result channel: one transaction per string (result_valid / result_stall),
// value in two's complement with FRAC_BITS fraction bits, overflow set when
// the integer part saturated.
// a character is registered in the input register when accepted and is
// folded into the parse state from there; a closing character instead lands
// in the result register, which raises result_valid. throughput: one
// character per cycle, set by the single multiply-add per digit between the
// input and state registers, while no closing character waits on a stalled
// result. a stalled result blocks only a closing character: ordinary
// characters keep flowing while a result waits.
// reset clears the parse state and both valid flags; no result is pending.
`default_nettype none

module decimal_text_to_fixed_point
    import dtfx_pkg::*;
#(
    parameter int INT_BITS    = DEF_INT_BITS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         char_valid,
    output      logic         char_stall,
    input  wire dtfx_char_t   char_data,
    output      logic         result_valid,
    input  wire logic         result_stall,
    output      dtfx_result_t result
);

    localparam dtfx_flags_t FLAGS_RESET = '{phase: PH_LEAD, negative: 1'b0, saturated: 1'b0};

    // input register
    logic       in_vld_reg;
    dtfx_char_t in_reg;

    // parse state
    dtfx_flags_t            flags_reg;
    logic [INT_BITS-1:0]    whole_reg;
    logic [WEIGHT_BITS-1:0] frac_reg;
    logic [WCNT_W-1:0]      wcnt_reg;

    // result register
    logic         out_vld_reg;
    dtfx_result_t out_reg;

    // next values from the digit step
    dtfx_flags_t            flags_next;
    logic [INT_BITS-1:0]    whole_next;
    logic [WEIGHT_BITS-1:0] frac_next;
    logic [WCNT_W-1:0]      wcnt_next;

    logic        out_free;
    logic        advance;
    logic [63:0] frac_out;
    logic [63:0] magnitude;

    dtfx_step #(
        .INT_BITS    (INT_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_step (
        .character  (in_reg.character),
        .flags      (flags_reg),
        .whole      (whole_reg),
        .frac       (frac_reg),
        .wcnt       (wcnt_reg),
        .flags_next (flags_next),
        .whole_next (whole_next),
        .frac_next  (frac_next),
        .wcnt_next  (wcnt_next)
    );

    // result slot is free when empty or being taken this cycle
    assign out_free = !out_vld_reg || !result_stall;
    // a registered character moves on unless it closes a string and the slot is full
    assign advance  = in_vld_reg && (!in_reg.end_of_string || out_free);
    assign char_stall = in_vld_reg && !advance;

    // align the fraction to FRAC_BITS by truncation or left shift
    if (WEIGHT_BITS >= FRAC_BITS)
    begin : g_frac_trunc
        assign frac_out = 64'(frac_next >> (WEIGHT_BITS - FRAC_BITS));
    end
    else
    begin : g_frac_shift
        assign frac_out = 64'(frac_next) << (FRAC_BITS - WEIGHT_BITS);
    end

    // fraction stays below 2^FRAC_BITS, so the parts do not overlap
    assign magnitude = (64'(whole_next) << FRAC_BITS) | frac_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            flags_reg   <= FLAGS_RESET;
            whole_reg   <= '0;
            frac_reg    <= '0;
            wcnt_reg    <= '0;
        end
        else
        begin
            if (!char_stall)
            begin
                in_vld_reg <= char_valid;
            end

            if (advance && in_reg.end_of_string)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_vld_reg <= 1'b0;
            end

            if (advance)
            begin
                if (in_reg.end_of_string)
                begin
                    // string closed: back to the start state
                    flags_reg <= FLAGS_RESET;
                    whole_reg <= '0;
                    frac_reg  <= '0;
                    wcnt_reg  <= '0;
                end
                else
                begin
                    flags_reg <= flags_next;
                    whole_reg <= whole_next;
                    frac_reg  <= frac_next;
                    wcnt_reg  <= wcnt_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            in_reg <= char_data;
        end
        if (advance && in_reg.end_of_string)
        begin
            out_reg.value    <= flags_next.negative ? -magnitude : magnitude;
            out_reg.overflow <= flags_next.saturated;
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

`ifndef SYNTH
    localparam logic [INT_BITS-1:0] WHOLE_LIM = INT_BITS'(whole_limit(INT_BITS, FRAC_BITS));

    // saturation pins the integer part at its limit
    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg.saturated |-> whole_reg == WHOLE_LIM)
        else $error("saturated integer part is not at its limit");

    // fraction weights only advance after a point
    a_wcnt_phase: assert property (@(posedge clk) disable iff (!rst_n)
        wcnt_reg != '0 |-> (flags_reg.phase == PH_FRAC || flags_reg.phase == PH_STOP))
        else $error("fraction position moved outside the fraction");

    // closing a string returns the parse state to its start
    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_reg.end_of_string |=>
            flags_reg.phase == PH_LEAD && whole_reg == '0 && frac_reg == '0
            && wcnt_reg == '0 && !flags_reg.saturated)
        else $error("parse state not cleared after end of string");

    // the input side only stalls behind a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> result_valid && result_stall)
        else $error("character stalled without a blocked result");
`endif

endmodule

`default_nettype wire
